@@ rtl/nearest_timestamp_matcher_top_assert.svh @@
`ifndef NEAREST_TIMESTAMP_MATCHER_TOP_ASSERT_SVH
`define NEAREST_TIMESTAMP_MATCHER_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define NTM_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// next-cycle implication, checked outside reset
`define NTM_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

@@ rtl/ntm_pkg.sv @@
`timescale 1ns / 1ps
package ntm_pkg;

  localparam int STAMP_W = 48;
  localparam int TAG_W   = 32;
  localparam int CMD_W   = 2;

  localparam int DEPTH_LEN_DEF = 16;
  localparam int POSE_LEN_DEF  = 16;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CMD_W-1:0] CMD_ADD_DEPTH = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD_POSE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY     = 2'd2;

  localparam logic [STAMP_W-1:0] GAP_NONE = {STAMP_W{1'b1}};

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [STAMP_W-1:0] stamp;
    logic [TAG_W-1:0]   entry_tag;
  } req_t;

  typedef struct packed {
    logic [TAG_W-1:0]   color_tag;
    logic               depth_found;
    logic [TAG_W-1:0]   depth_tag;
    logic [STAMP_W-1:0] depth_gap;
    logic               pose_found;
    logic [TAG_W-1:0]   pose_tag;
    logic [STAMP_W-1:0] pose_gap;
  } rsp_t;

  typedef struct packed {
    logic [CMD_W-1:0]   op;
    logic               use_depth;
    logic [STAMP_W-1:0] stamp;
    logic [TAG_W-1:0]   tag;
  } job_t;

  typedef struct packed {
    logic               found;
    logic [TAG_W-1:0]   tag;
    logic [STAMP_W-1:0] gap;
  } walk_res_t;

endpackage

@@ rtl/ntm_front.sv @@
`timescale 1ns / 1ps
module ntm_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic          cfg_data,
  input  logic          req_valid,
  output logic          req_ready,
  input  ntm_pkg::req_t req,
  input  logic          room,
  output logic          push,
  output ntm_pkg::job_t job
);
  import ntm_pkg::*;

  logic depth_enable;
  logic keep;

  assign cfg_ready = 1'b1;
  assign req_ready = room;

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_enable <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      depth_enable <= cfg_data;
    end
  end

  always_comb begin
    unique case (req.command)
      CMD_ADD_DEPTH: keep = depth_enable;
      CMD_ADD_POSE:  keep = 1'b1;
      CMD_QUERY:     keep = 1'b1;
      default:       keep = 1'b0;
    endcase
  end

  assign push          = req_valid && req_ready && keep;
  assign job.op        = req.command;
  assign job.use_depth = depth_enable;
  assign job.stamp     = req.stamp;
  assign job.tag       = req.entry_tag;

endmodule

@@ rtl/ntm_queue.sv @@
`timescale 1ns / 1ps
module ntm_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ntm_pkg::job_t push_job,
  output logic          room,
  output logic          job_valid,
  input  logic          job_ready,
  output ntm_pkg::job_t job
);
  import ntm_pkg::*;

  job_t                slot [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_CW-1:0] fill;
  logic                pop;

  assign room      = (fill != QUEUE_CW'(QUEUE_DEPTH));
  assign job_valid = (fill != '0);
  assign job       = slot[rd_ptr];
  assign pop       = job_valid && job_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_job;
    end
  end

endmodule

@@ rtl/ntm_walk.sv @@
`timescale 1ns / 1ps
module ntm_walk #(
  parameter int LEN = ntm_pkg::DEPTH_LEN_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        wr_en,
  input  logic [ntm_pkg::STAMP_W-1:0] wr_stamp,
  input  logic [ntm_pkg::TAG_W-1:0]   wr_tag,
  input  logic                        start,
  input  logic [ntm_pkg::STAMP_W-1:0] query,
  output logic                        busy,
  output ntm_pkg::walk_res_t          res
);
  import ntm_pkg::*;

  localparam int AW = (LEN > 1) ? $clog2(LEN) : 1;
  localparam int CW = $clog2(LEN + 1);

  logic [STAMP_W-1:0] stamps [LEN];
  logic [TAG_W-1:0]   tags   [LEN];

  logic [AW-1:0]      head;
  logic [CW-1:0]      count;
  logic [AW-1:0]      pos;
  logic [CW-1:0]      left;
  logic               rd_valid;
  logic               have;
  logic [STAMP_W-1:0] rd_stamp;
  logic [TAG_W-1:0]   rd_tag;
  logic [STAMP_W-1:0] query_q;
  logic [STAMP_W-1:0] best;
  logic [TAG_W-1:0]   best_tag;

  logic [AW-1:0]      head_dec;
  logic [AW-1:0]      pos_dec;
  logic [STAMP_W-1:0] diff;
  logic               closer;
  logic               stop_now;
  logic               issue;
  logic               finish;

  assign head_dec = (head == '0) ? AW'(LEN - 1) : head - 1'b1;
  assign pos_dec  = (pos == '0) ? AW'(LEN - 1) : pos - 1'b1;
  assign diff     = (rd_stamp >= query_q) ? rd_stamp - query_q : query_q - rd_stamp;
  assign closer   = !have || (diff < best);
  assign stop_now = busy && rd_valid && !closer;
  assign issue    = busy && (left != '0) && !stop_now;
  assign finish   = busy && (stop_now || ((left == '0) && !rd_valid));

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      count    <= '0;
      busy     <= 1'b0;
      rd_valid <= 1'b0;
      have     <= 1'b0;
    end else begin
      if (wr_en) begin
        head <= (head == AW'(LEN - 1)) ? '0 : head + 1'b1;
        if (count != CW'(LEN)) begin
          count <= count + 1'b1;
        end
      end
      if (start) begin
        busy     <= (count != '0);
        rd_valid <= 1'b0;
        have     <= 1'b0;
      end else if (busy) begin
        rd_valid <= issue;
        if (rd_valid && closer) begin
          have <= 1'b1;
        end
        if (finish) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      stamps[head] <= wr_stamp;
      tags[head]   <= wr_tag;
    end
    if (issue) begin
      rd_stamp <= stamps[pos];
      rd_tag   <= tags[pos];
    end
    if (start) begin
      pos      <= head_dec;
      left     <= count;
      query_q  <= query;
      best     <= GAP_NONE;
      best_tag <= '0;
    end else begin
      if (issue) begin
        pos  <= pos_dec;
        left <= left - 1'b1;
      end
      if (busy && rd_valid && closer) begin
        best     <= diff;
        best_tag <= rd_tag;
      end
    end
  end

  assign res.found = have;
  assign res.tag   = best_tag;
  assign res.gap   = best;

endmodule

@@ rtl/ntm_back.sv @@
`timescale 1ns / 1ps
module ntm_back #(
  parameter int DEPTH_LEN = ntm_pkg::DEPTH_LEN_DEF,
  parameter int POSE_LEN  = ntm_pkg::POSE_LEN_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          job_valid,
  output logic          job_ready,
  input  ntm_pkg::job_t job,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output ntm_pkg::rsp_t rsp
);
  import ntm_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_WAIT = 1'b1;

  logic              state;
  logic              state_next;
  logic              take;
  logic              use_depth;
  logic [TAG_W-1:0]  color_tag;
  logic              d_busy;
  logic              p_busy;
  walk_res_t         d_res;
  walk_res_t         p_res;
  logic              load;
  rsp_t              rsp_next;

  assign job_ready = (state == S_IDLE);
  assign take      = job_valid && job_ready;

  ntm_walk #(.LEN(DEPTH_LEN)) u_depth (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (take && (job.op == CMD_ADD_DEPTH)),
    .wr_stamp (job.stamp),
    .wr_tag   (job.tag),
    .start    (take && (job.op == CMD_QUERY) && job.use_depth),
    .query    (job.stamp),
    .busy     (d_busy),
    .res      (d_res)
  );

  ntm_walk #(.LEN(POSE_LEN)) u_pose (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (take && (job.op == CMD_ADD_POSE)),
    .wr_stamp (job.stamp),
    .wr_tag   (job.tag),
    .start    (take && (job.op == CMD_QUERY)),
    .query    (job.stamp),
    .busy     (p_busy),
    .res      (p_res)
  );

  always_comb begin
    state_next = state;
    load       = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (take && (job.op == CMD_QUERY)) begin
          state_next = S_WAIT;
        end
      end
      S_WAIT: begin
        if (!d_busy && !p_busy && (!rsp_valid || rsp_ready)) begin
          load       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    rsp_next.color_tag   = color_tag;
    rsp_next.depth_found = use_depth ? d_res.found : 1'b0;
    rsp_next.depth_tag   = use_depth ? d_res.tag : '0;
    rsp_next.depth_gap   = use_depth ? d_res.gap : GAP_NONE;
    rsp_next.pose_found  = p_res.found;
    rsp_next.pose_tag    = p_res.tag;
    rsp_next.pose_gap    = p_res.gap;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      use_depth <= job.use_depth;
      color_tag <= job.tag;
    end
    if (load) begin
      rsp <= rsp_next;
    end
  end

endmodule

@@ rtl/nearest_timestamp_matcher_top.sv @@
`timescale 1ns / 1ps
// channel   signals                      word
// cfg       cfg_valid / cfg_ready        cfg_data: depth_enable
// request   req_valid / req_ready        req: command, stamp, entry_tag
// response  rsp_valid / rsp_ready        rsp: color tag, depth and pose matches
//
// An add passes through the two-entry queue and is written when the back end takes it.
// A query is answered once both buffer walks are done and the response register is free;
// each buffer memory is read once per cycle, newest first.
// Reset empties both buffers and sets depth_enable; no clearing pass.
// The response register holds a result until taken; adds behind it keep going.
module nearest_timestamp_matcher_top #(
  parameter int DEPTH_LEN = ntm_pkg::DEPTH_LEN_DEF,
  parameter int POSE_LEN  = ntm_pkg::POSE_LEN_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic          cfg_data,
  input  logic          req_valid,
  output logic          req_ready,
  input  ntm_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output ntm_pkg::rsp_t rsp
);
  import ntm_pkg::*;
  `include "nearest_timestamp_matcher_top_assert.svh"

  logic room;
  logic push;
  job_t push_job;
  logic job_valid;
  logic job_ready;
  job_t job;

  ntm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .room      (room),
    .push      (push),
    .job       (push_job)
  );

  ntm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .room      (room),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job)
  );

  ntm_back #(
    .DEPTH_LEN (DEPTH_LEN),
    .POSE_LEN  (POSE_LEN)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  `NTM_ASSERT_NOW(a_push_room, push, room, "push into full queue")
  `NTM_ASSERT_NOW(a_depth_none, rsp_valid && !rsp.depth_found,
    (rsp.depth_tag == '0) && (rsp.depth_gap == GAP_NONE), "bad empty depth match")
  `NTM_ASSERT_NOW(a_pose_none, rsp_valid && !rsp.pose_found,
    (rsp.pose_tag == '0) && (rsp.pose_gap == GAP_NONE), "bad empty pose match")
  `NTM_ASSERT_NEXT(a_query_busy, job_valid && job_ready && (job.op == CMD_QUERY),
    !job_ready, "back end took a job during a query")

endmodule

@@ verif/nearest_timestamp_matcher_top_test.sv @@
`timescale 1ns / 1ps
module nearest_timestamp_matcher_top_test;
  import ntm_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int BUF_DEPTH = 0;
  localparam int BUF_POSE = 1;
  localparam int RING_MAX = (DEPTH_LEN_DEF > POSE_LEN_DEF) ? DEPTH_LEN_DEF : POSE_LEN_DEF;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASES = 6;
  localparam int PHASE_WORDS = 250;
  localparam int MAX_REPORTS = 10;
  localparam int STAMP_STEP = 1500;

  typedef enum int {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_PERIODIC} ready_mode_e;

  class stamp_match_board;
    logic [STAMP_W-1:0] stamps [2][RING_MAX];
    logic [TAG_W-1:0] tags [2][RING_MAX];
    int head [2];
    int count [2];
    bit depth_enable;
    rsp_t expected_matches [$];
    int failures;

    function new();
      head[BUF_DEPTH] = 0;
      head[BUF_POSE] = 0;
      count[BUF_DEPTH] = 0;
      count[BUF_POSE] = 0;
      depth_enable = 1'b1;
      failures = 0;
    endfunction

    function int ring_len(int b);
      return (b == BUF_DEPTH) ? DEPTH_LEN_DEF : POSE_LEN_DEF;
    endfunction

    function void store(int b, req_t w);
      stamps[b][head[b]] = w.stamp;
      tags[b][head[b]] = w.entry_tag;
      head[b] = (head[b] + 1) % ring_len(b);
      if (count[b] < ring_len(b)) count[b]++;
    endfunction

    // newest to oldest, stop at the first entry that is not strictly closer
    function walk_res_t nearest(int b, logic [STAMP_W-1:0] q);
      walk_res_t best;
      int pos;
      int i;
      bit done;
      logic [STAMP_W-1:0] d;
      best.found = 1'b0;
      best.tag = '0;
      best.gap = GAP_NONE;
      pos = head[b];
      done = 1'b0;
      for (i = 0; i < count[b] && !done; i++) begin
        pos = (pos == 0) ? ring_len(b) - 1 : pos - 1;
        d = (stamps[b][pos] >= q) ? stamps[b][pos] - q : q - stamps[b][pos];
        if (!best.found || d < best.gap) begin
          best.found = 1'b1;
          best.gap = d;
          best.tag = tags[b][pos];
        end else begin
          done = 1'b1;
        end
      end
      return best;
    endfunction

    function void note_request(req_t w);
      rsp_t exp;
      walk_res_t hit;
      case (w.command)
        CMD_ADD_DEPTH: begin
          if (depth_enable) store(BUF_DEPTH, w);
        end
        CMD_ADD_POSE: begin
          store(BUF_POSE, w);
        end
        CMD_QUERY: begin
          exp.color_tag = w.entry_tag;
          if (depth_enable) begin
            hit = nearest(BUF_DEPTH, w.stamp);
          end else begin
            hit.found = 1'b0;
            hit.tag = '0;
            hit.gap = GAP_NONE;
          end
          exp.depth_found = hit.found;
          exp.depth_tag = hit.tag;
          exp.depth_gap = hit.gap;
          hit = nearest(BUF_POSE, w.stamp);
          exp.pose_found = hit.found;
          exp.pose_tag = hit.tag;
          exp.pose_gap = hit.gap;
          expected_matches = {expected_matches, exp};
        end
        default: begin
        end
      endcase
    endfunction

    function void check_response(rsp_t got);
      rsp_t exp;
      if (expected_matches.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("unexpected response, color tag %h", got.color_tag);
        return;
      end
      exp = expected_matches.pop_front();
      if (got.color_tag !== exp.color_tag || got.depth_found !== exp.depth_found ||
          got.depth_tag !== exp.depth_tag || got.depth_gap !== exp.depth_gap ||
          got.pose_found !== exp.pose_found || got.pose_tag !== exp.pose_tag ||
          got.pose_gap !== exp.pose_gap) begin
        failures++;
        if (failures <= MAX_REPORTS) begin
          $display("mismatch expected: color %h depth %b %h %h pose %b %h %h",
                   exp.color_tag, exp.depth_found, exp.depth_tag, exp.depth_gap,
                   exp.pose_found, exp.pose_tag, exp.pose_gap);
          $display("              got: color %h depth %b %h %h pose %b %h %h",
                   got.color_tag, got.depth_found, got.depth_tag, got.depth_gap,
                   got.pose_found, got.pose_tag, got.pose_gap);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_data = 1'b0;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  stamp_match_board board;
  logic [STAMP_W-1:0] now_us = '0;
  int cycle_count = 0;
  ready_mode_e ready_mode = READY_ALWAYS;
  int mode_left = 0;
  int ready_tick = 0;

  always #5 clk = ~clk;

  nearest_timestamp_matcher_top uut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) board.check_response(rsp);
    ready_tick <= ready_tick + 1;
    if (mode_left == 0) begin
      ready_mode <= ready_mode_e'($urandom_range(0, 3));
      mode_left <= $urandom_range(32, 256);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (ready_mode)
      READY_ALWAYS: rsp_ready <= 1'b1;
      READY_COIN: rsp_ready <= 1'($urandom_range(0, 1));
      READY_SPARSE: rsp_ready <= ($urandom_range(0, 5) == 0);
      default: rsp_ready <= (ready_tick % 7) < 3;
    endcase
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  function automatic req_t make_req(logic [CMD_W-1:0] c, logic [STAMP_W-1:0] s,
                                    logic [TAG_W-1:0] t);
    req_t w;
    w.command = c;
    w.stamp = s;
    w.entry_tag = t;
    return w;
  endfunction

  // mostly a rising sensor clock; queries land near or behind it
  function automatic req_t next_word();
    req_t w;
    int pick;
    pick = $urandom_range(0, 99);
    w.entry_tag = $urandom;
    if (pick < 5) begin
      w.command = CMD_W'($urandom_range(0, 3));
      w.stamp = STAMP_W'({$urandom, $urandom});
    end else if (pick < 75) begin
      w.command = (pick < 40) ? CMD_ADD_DEPTH : CMD_ADD_POSE;
      now_us = now_us + $urandom_range(0, 3000);
      w.stamp = now_us;
      if ($urandom_range(0, 9) == 0) w.stamp = now_us - $urandom_range(0, 500);
    end else begin
      w.command = CMD_QUERY;
      if ($urandom_range(0, 4) == 0)
        w.stamp = now_us + $urandom_range(0, 5000);
      else
        w.stamp = now_us - ($urandom_range(0, 40) * STAMP_STEP + $urandom_range(0, STAMP_STEP));
    end
    return w;
  endfunction

  task automatic send_word(input req_t w);
    req_valid <= 1'b1;
    req <= w;
    do @(posedge clk); while (!req_ready);
    board.note_request(w);
  endtask

  task automatic pause_sender(input int cycles);
    req_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (board.expected_matches.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_depth_enable(input bit value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    board.depth_enable = value;
    cfg_valid <= 1'b0;
  endtask

  initial begin
    req_t w;
    int phase;
    int sent;
    int burst;
    int gap;
    bit enable;
    board = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    write_depth_enable(1'b1);
    send_word(make_req(CMD_QUERY, '0, '0));
    send_word(make_req(CMD_ADD_DEPTH, '0, '1));
    send_word(make_req(CMD_ADD_POSE, GAP_NONE, '0));
    send_word(make_req(CMD_QUERY, GAP_NONE, '1));
    send_word(make_req(CMD_QUERY, '0, 32'h0000_0001));
    send_word(make_req(CMD_UNUSED, GAP_NONE, '1));
    send_word(make_req(CMD_ADD_DEPTH, 48'd1000, 32'd1));
    send_word(make_req(CMD_ADD_DEPTH, 48'd2000, 32'd2));
    // equidistant: newer record wins
    send_word(make_req(CMD_QUERY, 48'd1500, 32'd10));
    send_word(make_req(CMD_QUERY, 48'd1000, 32'd11));
    send_word(make_req(CMD_ADD_POSE, 48'd5000, 32'd5));
    send_word(make_req(CMD_ADD_POSE, 48'd6000, 32'd6));
    send_word(make_req(CMD_ADD_POSE, 48'd7000, 32'd7));
    send_word(make_req(CMD_QUERY, 48'd5100, 32'd12));
    write_depth_enable(1'b0);
    send_word(make_req(CMD_ADD_DEPTH, 48'd3000, 32'd3));
    send_word(make_req(CMD_QUERY, 48'd3000, 32'd13));
    write_depth_enable(1'b1);
    send_word(make_req(CMD_QUERY, 48'd3000, 32'd14));

    for (phase = 0; phase < PHASES; phase++) begin
      if (phase == 0) enable = 1'b1;
      else if (phase == 1) enable = 1'b0;
      else enable = $urandom_range(0, 1);
      write_depth_enable(enable);
      case ($urandom_range(0, 2))
        0: now_us = '0;
        1: now_us = GAP_NONE - 48'd3000000;
        default: now_us = STAMP_W'({$urandom, $urandom});
      endcase
      sent = 0;
      burst = $urandom_range(1, 40);
      while (sent < PHASE_WORDS) begin
        w = next_word();
        send_word(w);
        sent++;
        burst--;
        if (burst == 0) begin
          gap = $urandom_range(0, 12);
          if ($urandom_range(0, 29) == 0) drain();
          else if (gap > 0) pause_sender(gap);
          burst = $urandom_range(1, 40);
        end
      end
    end

    drain();
    if (board.failures == 0 && board.expected_matches.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end
endmodule

@@ files.f @@
+incdir+rtl
rtl/ntm_pkg.sv
rtl/ntm_front.sv
rtl/ntm_queue.sv
rtl/ntm_walk.sv
rtl/ntm_back.sv
rtl/nearest_timestamp_matcher_top.sv
verif/nearest_timestamp_matcher_top_test.sv
